// ===== rtl/okvt_pkg.sv =====
// okvt_pkg: shared types, sizes and operation/status codes for the
// ordered key/value table. No dependencies.
`default_nettype none

package okvt_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int KEY_WIDTH   = 64;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // operation codes carried in the mode field
  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_FIRST  = 3'd2;
  localparam logic [2:0] OP_LAST   = 3'd3;
  localparam logic [2:0] OP_NEXT   = 3'd4;
  localparam logic [2:0] OP_REMOVE = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]           mode;
    logic [KEY_WIDTH-1:0] key;
    logic [31:0]          value;
  } in_t;

  typedef struct packed {
    logic                 ok;
    logic [1:0]           status;
    logic [KEY_WIDTH-1:0] key_out;
    logic [31:0]          value_out;
    logic [4:0]           count;
  } out_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic live;  // cell lies inside the search window
    logic load;  // cell takes the new pair (put)
    logic rem;   // remove with a hit is being committed
    logic tail;  // an occupied neighbour sits above this cell
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/okvt_cell.sv =====
// okvt_cell: one table slot holding a key/value pair, its key compare
// and a link in the first-match chain. Depends on okvt_pkg.
`default_nettype none

module okvt_cell (
  input  wire logic                              clk,
  input  wire okvt_pkg::cell_ctl_t               ctl,
  input  wire logic [okvt_pkg::KEY_WIDTH-1:0]    cmp_key,
  input  wire logic [okvt_pkg::KEY_WIDTH-1:0]    new_key,
  input  wire logic [okvt_pkg::VALUE_WIDTH-1:0]  new_val,
  input  wire logic [okvt_pkg::KEY_WIDTH-1:0]    nbr_key,
  input  wire logic [okvt_pkg::VALUE_WIDTH-1:0]  nbr_val,
  input  wire logic                              seen_in,
  output logic                                   seen_out,
  output logic                                   hit,
  output logic [okvt_pkg::KEY_WIDTH-1:0]         key_q,
  output logic [okvt_pkg::VALUE_WIDTH-1:0]       val_q
);

  logic [okvt_pkg::KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [okvt_pkg::VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                             eq;
  logic                             shift;

  assign eq       = ctl.live && (key_r == cmp_key);
  assign hit      = eq && !seen_in;
  assign seen_out = seen_in || eq;
  // at or above the removed slot: pull the neighbour down
  assign shift    = ctl.rem && ctl.tail && (seen_in || eq);

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    if (ctl.load) begin
      key_nxt = new_key;
      val_nxt = new_val;
    end else if (shift) begin
      key_nxt = nbr_key;
      val_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign key_q = key_r;
  assign val_q = val_r;

endmodule

`default_nettype wire

// ===== rtl/ordered_key_value_table.sv =====
// ordered_key_value_table: top level; command sequencer, row of okvt_cell
// slots, result selection and output register. Depends on okvt_pkg, okvt_cell.
`default_nettype none

//  channel   ports                          payload
//  input     in_valid / in_ready / in_data  okvt_pkg::in_t  (mode, key, value)
//  result    out_valid/ out_ready/ out_data okvt_pkg::out_t (ok, status, ..., count)
//
//  Each item is captured in the idle state, then in the execute state all
//  cells compare in parallel, the first-match chain settles and the table
//  commits (append, or a one-step shift down for remove).
//  One item is in flight at a time; the next is taken while a result waits.
//  A stalled result holds the command in the execute state; nothing moves.
//  Synchronous active-low reset empties the table (count to zero); the
//  slot contents are not cleared and are never read before being written.

module ordered_key_value_table (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire okvt_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output okvt_pkg::out_t      out_data
);

  localparam int D  = okvt_pkg::DEPTH;
  localparam int CW = okvt_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  okvt_pkg::in_t       cmd_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                out_valid_r;
  okvt_pkg::out_t      out_data_r, res;

  logic                exec_go;
  logic [CW-1:0]       lim;
  logic                not_full;
  logic                found;

  logic [D:0]                              seen;
  logic [D-1:0]                            hit;
  okvt_pkg::cell_ctl_t                     ctl [D];
  logic [okvt_pkg::KEY_WIDTH-1:0]          key_q [D];
  logic [okvt_pkg::VALUE_WIDTH-1:0]        val_q [D];
  logic [okvt_pkg::KEY_WIDTH-1:0]          sel_key;
  logic [okvt_pkg::VALUE_WIDTH-1:0]        sel_val;

  // commit when the result register is free or being drained
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);
  assign not_full = (cnt_r < CW'(D));

  // next searches one short so the successor always exists
  always_comb begin
    if (cmd_r.mode == okvt_pkg::OP_NEXT) begin
      lim = (cnt_r == '0) ? '0 : cnt_r - CW'(1);
    end else begin
      lim = cnt_r;
    end
  end

  assign seen[0] = 1'b0;
  assign found   = seen[D];

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign ctl[i].live = (CW'(i) < lim);
    assign ctl[i].load = exec_go && (cmd_r.mode == okvt_pkg::OP_PUT) && (cnt_r == CW'(i));
    assign ctl[i].rem  = exec_go && (cmd_r.mode == okvt_pkg::OP_REMOVE) && found;
    assign ctl[i].tail = ((CW + 1)'(i + 1) < (CW + 1)'(cnt_r));

    okvt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .cmp_key  (cmd_r.key),
      .new_key  (cmd_r.key),
      .new_val  (okvt_pkg::VALUE_WIDTH'(cmd_r.value)),
      .nbr_key  ((i + 1 < D) ? key_q[(i + 1) % D] : '0),
      .nbr_val  ((i + 1 < D) ? val_q[(i + 1) % D] : '0),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .hit      (hit[i]),
      .key_q    (key_q[i]),
      .val_q    (val_q[i])
    );
  end

  // one-hot pick of the returned slot, ORed across the row
  always_comb begin
    logic sel;
    sel_key = '0;
    sel_val = '0;
    for (int i = 0; i < D; i++) begin
      case (cmd_r.mode)
        okvt_pkg::OP_GET:   sel = hit[i];
        okvt_pkg::OP_FIRST: sel = (i == 0);
        okvt_pkg::OP_LAST:  sel = ((CW + 1)'(cnt_r) == (CW + 1)'(i + 1));
        okvt_pkg::OP_NEXT:  sel = (i > 0) ? hit[(i + D - 1) % D] : 1'b0;
        default:            sel = 1'b0;
      endcase
      if (sel) begin
        sel_key = sel_key | key_q[i];
        sel_val = sel_val | val_q[i];
      end
    end
  end

  // result and new count
  always_comb begin
    res         = '0;
    res.status  = okvt_pkg::ST_MISS;
    cnt_nxt     = cnt_r;
    case (cmd_r.mode) inside
      okvt_pkg::OP_PUT: begin
        if (not_full) begin
          res.ok  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          res.status = okvt_pkg::ST_FULL;
        end
      end
      okvt_pkg::OP_GET: begin
        res.ok        = found;
        res.value_out = found ? 32'(sel_val) : '0;
      end
      okvt_pkg::OP_FIRST, okvt_pkg::OP_LAST, okvt_pkg::OP_NEXT: begin
        res.ok = (cmd_r.mode == okvt_pkg::OP_NEXT) ? found : (cnt_r != '0);
        if (res.ok) begin
          res.key_out   = sel_key;
          res.value_out = 32'(sel_val);
        end
      end
      okvt_pkg::OP_REMOVE: begin
        res.ok = found;
        if (found) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (res.ok) begin
      res.status = okvt_pkg::ST_OK;
    end
    res.count = 5'(cnt_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data;
    end
    if (exec_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(D))
    else $error("entry count above depth");

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hit))
    else $error("more than one first match");

  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && cmd_r.mode == okvt_pkg::OP_PUT && not_full)
      |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("accepted put did not grow the table");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.ok == (out_data_r.status == okvt_pkg::ST_OK)))
    else $error("ok and status disagree");

  a_found_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && lim == '0) |-> !found)
    else $error("match outside search window");
`endif

endmodule

`default_nettype wire

// ===== dv/okvt_checker.sv =====
// okvt_checker: watches both channels of the ordered key/value table, models
// the table contents and compares every result transfer in order.
// Depends on okvt_pkg.
`default_nettype none

module okvt_checker
  import okvt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_ready,
  input  wire in_t   in_data,
  input  wire logic  out_valid,
  input  wire logic  out_ready,
  input  wire out_t  out_data,
  output int         fail_count,
  output int         pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_WIDTH-1:0]   table_keys [DEPTH];
  logic [VALUE_WIDTH-1:0] table_vals [DEPTH];
  int                     table_fill;
  out_t                   expected_results [$];

  // oldest slot below limit holding key, or -1
  function automatic int oldest_match(logic [KEY_WIDTH-1:0] key, int limit);
    for (int i = 0; i < limit && i < DEPTH; i++) begin
      if (table_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic out_t apply_table_op(in_t cmd);
    out_t r;
    int   n;
    int   hit;
    int   j;
    r        = '0;
    r.status = ST_MISS;
    n        = table_fill;
    case (cmd.mode)
      OP_PUT: begin
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          table_keys[n] = cmd.key;
          table_vals[n] = cmd.value[VALUE_WIDTH-1:0];
          n++;
          r.ok     = 1'b1;
          r.status = ST_OK;
        end
      end
      OP_GET: begin
        hit = oldest_match(cmd.key, n);
        if (hit >= 0) begin
          r.value_out = table_vals[hit];
          r.ok        = 1'b1;
          r.status    = ST_OK;
        end
      end
      OP_FIRST, OP_LAST: begin
        if (n > 0) begin
          j           = (cmd.mode == OP_FIRST) ? 0 : n - 1;
          r.key_out   = table_keys[j];
          r.value_out = table_vals[j];
          r.ok        = 1'b1;
          r.status    = ST_OK;
        end
      end
      OP_NEXT: begin
        // the newest pair has no successor; later duplicates are not searched
        if (n > 1) begin
          hit = oldest_match(cmd.key, n - 1);
          if (hit >= 0) begin
            r.key_out   = table_keys[hit + 1];
            r.value_out = table_vals[hit + 1];
            r.ok        = 1'b1;
            r.status    = ST_OK;
          end
        end
      end
      OP_REMOVE: begin
        hit = oldest_match(cmd.key, n);
        if (hit >= 0) begin
          for (j = hit; j + 1 < n; j++) begin
            table_keys[j] = table_keys[j + 1];
            table_vals[j] = table_vals[j + 1];
          end
          n--;
          r.ok     = 1'b1;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    table_fill = n;
    r.count    = 5'(n);
    return r;
  endfunction

  // Sampled at the rising edge: inputs settle at the falling edge, and the
  // block's own updates at this edge are not yet visible.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      table_fill = 0;
      expected_results.delete();
      pending    = 0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing outstanding: %p", out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.key_out !== want.key_out) begin
            $error("key_out: expected %h, got %h", want.key_out, out_data.key_out);
            fail_count++;
          end
          if (out_data.value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, out_data.value_out);
            fail_count++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data.count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_table_op(in_data));
      end
      pending = expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== dv/ordered_key_value_table_tb.sv =====
// ordered_key_value_table_tb: drives command transfers into the table with
// random gaps and result back-pressure; verdict from okvt_checker.
// Depends on okvt_pkg, okvt_checker and the ordered_key_value_table RTL.
`default_nettype none

module ordered_key_value_table_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import okvt_pkg::*;

  // Mode codes the block must treat as no-ops
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // Slowest legal item: the block's own execution, the longest sender gap and
  // the longest result stall. The limit sits several times above what about
  // 1100 such items need.
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 6;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int   error_total;
  int   pending_results;
  bit   no_idle;

  logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

  ordered_key_value_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  okvt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (error_total),
    .pending    (pending_results)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop if the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [KEY_WIDTH-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Result side back-pressure. One nonblocking write per falling edge.
  initial begin
    int r;
    int len;
    bit level;
    out_ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) begin
        level = 1'b1;
        len   = $urandom_range(1, 6);
      end else if (r < 93) begin
        level = 1'b0;
        len   = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        len   = $urandom_range(10, 40);
      end
      repeat (len) begin
        @(negedge clk);
        out_ready <= level;
      end
    end
  end

  // One command transfer. Valid rises at a falling edge and holds until the
  // rising edge that sees ready; a zero gap leaves valid high for the next.
  task automatic push_op(logic [2:0] mode, logic [KEY_WIDTH-1:0] key, logic [31:0] value);
    int gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data.mode  <= mode;
    in_data.key   <= key;
    in_data.value <= value;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Random command: mostly keys from a small pool so that lookups, next and
  // remove actually hit; filling phases lean on put, draining on remove.
  task automatic random_item(bit filling);
    int                   r;
    logic [2:0]           mode;
    logic [KEY_WIDTH-1:0] key;
    logic [31:0]          value;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 50)      mode = OP_PUT;
      else if (r < 60) mode = OP_GET;
      else if (r < 66) mode = OP_FIRST;
      else if (r < 72) mode = OP_LAST;
      else if (r < 84) mode = OP_NEXT;
      else if (r < 96) mode = OP_REMOVE;
      else             mode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else begin
      if (r < 15)      mode = OP_PUT;
      else if (r < 27) mode = OP_GET;
      else if (r < 33) mode = OP_FIRST;
      else if (r < 39) mode = OP_LAST;
      else if (r < 51) mode = OP_NEXT;
      else if (r < 95) mode = OP_REMOVE;
      else             mode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end
    // a few stray keys to exercise the miss path
    if ($urandom_range(0, 99) < 12) key = rand_key();
    else                            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    r = $urandom_range(0, 19);
    if (r == 0)      value = '0;
    else if (r == 1) value = '1;
    else             value = $urandom();
    push_op(mode, key, value);
  endtask

  initial begin
    int phase;
    int n;
    // inputs known from time zero
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    no_idle  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, no-op modes, successor of the newest pair,
    // duplicates, fill to full, refused put, then first-match behaviour.
    push_op(OP_FIRST,  '0, '0);
    push_op(OP_LAST,   '0, '0);
    push_op(OP_GET,    '0, '0);
    push_op(OP_NEXT,   '0, '0);
    push_op(OP_REMOVE, '0, '0);
    push_op(OP_SPARE_A, '1, '1);
    push_op(OP_SPARE_B, '1, '1);
    push_op(OP_PUT,    '0, '0);
    push_op(OP_NEXT,   '0, '0);       // only pair is the newest
    push_op(OP_PUT,    '1, '1);
    for (n = 0; n < DEPTH - 2; n++) begin
      // duplicate of key zero lands in the middle
      push_op(OP_PUT, (n == 3) ? '0 : {32'hA5A5_0000 + n, 32'h5A5A_FFFF - n},
              32'h1234_0000 + n);
    end
    push_op(OP_PUT,    64'hDEAD_BEEF_0000_0001, 32'hFFFF_0000);  // refused: full
    push_op(OP_GET,    '0, '0);
    push_op(OP_NEXT,   '0, '0);
    push_op(OP_REMOVE, '0, '0);
    push_op(OP_GET,    '0, '0);       // now finds the later duplicate
    push_op(OP_LAST,   '0, '0);
    wait_drained();

    // Random: ten phases, two of them with no idling on either side
    for (phase = 0; phase < 10; phase++) begin
      no_idle = (phase == 0 || phase == 5);
      for (n = 0; n < POOL_SIZE - 1; n++) key_pool[n] = rand_key();
      key_pool[POOL_SIZE - 1] = (phase % 2) ? '1 : '0;
      for (n = 0; n < 105; n++) random_item(phase % 3 != 2);
      no_idle = 1'b0;
      if (phase % 3 == 1) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_total == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
